// ===== hdl/dle_rx_pkg.sv =====
package dle_rx_pkg;

   // receive phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_ESC  = 2'd2,
      PH_SUM  = 2'd3
   } phase_type;

   // result kinds carried on rsp_tuser
   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_GOOD    = 3'd1;
   localparam logic [2:0] KIND_BAD     = 3'd2;
   localparam logic [2:0] KIND_PACK    = 3'd3;
   localparam logic [2:0] KIND_PNAK    = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT = 3'd5;

   // command codes carried on req_tuser
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // control characters
   localparam logic [7:0] CH_STX = 8'h53;
   localparam logic [7:0] CH_ETX = 8'h45;
   localparam logic [7:0] CH_DLE = 8'h44;
   localparam logic [7:0] CH_ACK = 8'h41;
   localparam logic [7:0] CH_NAK = 8'h4E;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

endpackage

// ===== hdl/dle_frame_receiver.sv =====
// DLE framed receiver with an additive 8-bit checksum.
// Input stream (req_): one transaction is either a received serial byte
// (req_tuser = 0, byte in req_tdata) or one timer tick (req_tuser = 1).
// Result stream (rsp_): zero or one transaction per input transaction;
// rsp_tuser holds the kind (payload, frame good, frame bad, peer ack,
// peer nak, timeout) and rsp_tdata the payload byte or the reply byte.
// csr_we/csr_wdata load the inter-byte timeout in ticks; write it only
// while no frame is in progress.
// A result is registered and appears on rsp_ in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle while no result is pending or rsp_tready
// is high, set by the single result register that follows the frame state update.
// Reset clears the frame state, empties the result register and sets the
// timeout to 100 ticks.
// When the receiver stalls with a result pending, req_tready follows
// rsp_tready, so a new transaction is taken in the same cycle that the
// pending result leaves; otherwise input is held off.
module dle_frame_receiver #(
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] value
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] GAP_MAX = {TIMER_BITS{1'b1}};
   localparam logic [TIMER_BITS-1:0] GAP_ONE = TIMER_BITS'(1);

   dle_rx_pkg::phase_type phase_ff, phase_in;
   logic [7:0]            sum_ff, sum_in;
   logic [TIMER_BITS-1:0] gap_ff, gap_in;
   logic [15:0]           timeout_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_value_ff;
   logic [2:0]            rsp_kind_ff;

   logic                  accept;
   logic [TIMER_BITS-1:0] gap_inc;
   logic [CMP_W-1:0]      limit;
   logic                  timeout_hit;
   logic                  res_hit;
   logic [2:0]            res_kind;
   logic [7:0]            res_value;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign gap_inc = (gap_ff != GAP_MAX) ? gap_ff + GAP_ONE : gap_ff;

   // a narrow counter caps the limit at its all-ones value
   always_comb begin
      if (CMP_W'(timeout_ff) > CMP_W'(GAP_MAX)) begin
         limit = CMP_W'(GAP_MAX);
      end else begin
         limit = CMP_W'(timeout_ff);
      end
   end

   assign timeout_hit = CMP_W'(gap_inc) >= limit;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_tuser == dle_rx_pkg::CMD_TICK) begin
            if (phase_ff != dle_rx_pkg::PH_IDLE && timeout_hit) begin
               phase_in = dle_rx_pkg::PH_IDLE;
            end
         end else begin
            case (phase_ff)
               dle_rx_pkg::PH_IDLE: begin
                  if (req_tdata == dle_rx_pkg::CH_STX) phase_in = dle_rx_pkg::PH_DATA;
               end
               dle_rx_pkg::PH_DATA: begin
                  if (req_tdata == dle_rx_pkg::CH_DLE) phase_in = dle_rx_pkg::PH_ESC;
               end
               dle_rx_pkg::PH_ESC: begin
                  if (req_tdata == dle_rx_pkg::CH_DLE) begin
                     phase_in = dle_rx_pkg::PH_DATA;
                  end else if (req_tdata == dle_rx_pkg::CH_ETX) begin
                     phase_in = dle_rx_pkg::PH_SUM;
                  end
               end
               dle_rx_pkg::PH_SUM: phase_in = dle_rx_pkg::PH_IDLE;
               default:            phase_in = dle_rx_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // sum, gap counter and result
   always_comb begin
      sum_in    = sum_ff;
      gap_in    = gap_ff;
      res_hit   = 1'b0;
      res_kind  = dle_rx_pkg::KIND_PAYLOAD;
      res_value = req_tdata;
      if (accept) begin
         if (req_tuser == dle_rx_pkg::CMD_TICK) begin
            if (phase_ff != dle_rx_pkg::PH_IDLE) begin
               gap_in = gap_inc;
               if (timeout_hit) begin
                  gap_in    = '0;
                  res_hit   = 1'b1;
                  res_kind  = dle_rx_pkg::KIND_TIMEOUT;
                  res_value = 8'h00;
               end
            end
         end else begin
            case (phase_ff)
               dle_rx_pkg::PH_IDLE: begin
                  if (req_tdata == dle_rx_pkg::CH_STX) begin
                     sum_in = dle_rx_pkg::CH_STX;
                     gap_in = '0;
                  end else if (req_tdata == dle_rx_pkg::CH_ACK) begin
                     res_hit  = 1'b1;
                     res_kind = dle_rx_pkg::KIND_PACK;
                  end else if (req_tdata == dle_rx_pkg::CH_NAK) begin
                     res_hit  = 1'b1;
                     res_kind = dle_rx_pkg::KIND_PNAK;
                  end
               end
               dle_rx_pkg::PH_DATA: begin
                  gap_in = '0;
                  if (req_tdata != dle_rx_pkg::CH_DLE) begin
                     sum_in  = sum_ff + req_tdata;
                     res_hit = 1'b1;
                  end
               end
               dle_rx_pkg::PH_ESC: begin
                  gap_in = '0;
                  if (req_tdata == dle_rx_pkg::CH_DLE) begin
                     sum_in  = sum_ff + req_tdata;
                     res_hit = 1'b1;
                  end else if (req_tdata == dle_rx_pkg::CH_ETX) begin
                     sum_in = sum_ff + req_tdata;
                  end
                  // drop any other escaped byte
               end
               default: begin
                  gap_in  = '0;
                  res_hit = 1'b1;
                  if (req_tdata == sum_ff) begin
                     res_kind  = dle_rx_pkg::KIND_GOOD;
                     res_value = dle_rx_pkg::CH_ACK;
                  end else begin
                     res_kind  = dle_rx_pkg::KIND_BAD;
                     res_value = dle_rx_pkg::CH_NAK;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res_hit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dle_rx_pkg::PH_IDLE;
         sum_ff       <= '0;
         gap_ff       <= '0;
         timeout_ff   <= dle_rx_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) timeout_ff <= csr_wdata;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (accept && res_hit) begin
         rsp_kind_ff  <= res_kind;
         rsp_value_ff <= res_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_kind_ff;

   a_gap_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff == dle_rx_pkg::PH_IDLE |-> gap_ff == '0)
      else $error("gap counter running while idle");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !accept)
      else $error("transaction accepted over a pending result");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      accept && res_hit && (res_kind == dle_rx_pkg::KIND_GOOD ||
      res_kind == dle_rx_pkg::KIND_BAD || res_kind == dle_rx_pkg::KIND_TIMEOUT)
      |=> phase_ff == dle_rx_pkg::PH_IDLE)
      else $error("frame end did not return to idle");

   a_payload_in_frame: assert property (@(posedge clock) disable iff (reset)
      accept && res_hit && res_kind == dle_rx_pkg::KIND_PAYLOAD |->
      (phase_ff == dle_rx_pkg::PH_DATA || phase_ff == dle_rx_pkg::PH_ESC))
      else $error("payload outside a frame");

endmodule

// ===== tb/dle_frame_receiver_test.sv =====
module dle_frame_receiver_test;

   localparam int TIMER_BITS  = 16;
   localparam int GAP_MAX     = (1 << TIMER_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } rx_item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   dle_frame_receiver #(.TIMER_BITS(TIMER_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // serial bytes and ticks waiting to go out, and results the deframer owes
   rx_item_type rx_queue[$];
   rsp_type     predicted_results[$];

   // deframer state mirror
   dle_rx_pkg::phase_type rx_phase = dle_rx_pkg::PH_IDLE;
   logic [7:0]  rx_sum = 8'd0;
   int          gap_ticks = 0;
   logic [15:0] timeout_ticks = dle_rx_pkg::TIMEOUT_RESET;

   // generator side
   logic [7:0]  frame_sum;
   int          queued_items = 0;
   bit          steady_flow = 1'b0;

   int          fail_count = 0;
   int          rsp_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          cycle_count = 0;

   function automatic void deframe_step(input logic cmd, input logic [7:0] b,
                                        output bit got_result, output rsp_type res);
      int limit;
      got_result = 1'b0;
      res = '0;
      if (cmd == dle_rx_pkg::CMD_TICK) begin
         if (rx_phase != dle_rx_pkg::PH_IDLE) begin
            if (gap_ticks < GAP_MAX) gap_ticks++;
            limit = (int'(timeout_ticks) > GAP_MAX) ? GAP_MAX : int'(timeout_ticks);
            if (gap_ticks >= limit) begin
               rx_phase = dle_rx_pkg::PH_IDLE;
               gap_ticks = 0;
               got_result = 1'b1;
               res = '{kind: dle_rx_pkg::KIND_TIMEOUT, value: 8'd0};
            end
         end
      end else begin
         case (rx_phase)
            dle_rx_pkg::PH_IDLE: begin
               if (b == dle_rx_pkg::CH_STX) begin
                  rx_sum = dle_rx_pkg::CH_STX;
                  rx_phase = dle_rx_pkg::PH_DATA;
                  gap_ticks = 0;
               end else if (b == dle_rx_pkg::CH_ACK) begin
                  got_result = 1'b1;
                  res = '{kind: dle_rx_pkg::KIND_PACK, value: b};
               end else if (b == dle_rx_pkg::CH_NAK) begin
                  got_result = 1'b1;
                  res = '{kind: dle_rx_pkg::KIND_PNAK, value: b};
               end
            end
            dle_rx_pkg::PH_DATA: begin
               gap_ticks = 0;
               if (b == dle_rx_pkg::CH_DLE) begin
                  rx_phase = dle_rx_pkg::PH_ESC;
               end else begin
                  rx_sum = rx_sum + b;
                  got_result = 1'b1;
                  res = '{kind: dle_rx_pkg::KIND_PAYLOAD, value: b};
               end
            end
            dle_rx_pkg::PH_ESC: begin
               gap_ticks = 0;
               if (b == dle_rx_pkg::CH_DLE) begin
                  rx_sum = rx_sum + b;
                  rx_phase = dle_rx_pkg::PH_DATA;
                  got_result = 1'b1;
                  res = '{kind: dle_rx_pkg::KIND_PAYLOAD, value: b};
               end else if (b == dle_rx_pkg::CH_ETX) begin
                  rx_sum = rx_sum + b;
                  rx_phase = dle_rx_pkg::PH_SUM;
               end
               // any other byte is dropped and the escape stays open
            end
            default: begin
               rx_phase = dle_rx_pkg::PH_IDLE;
               gap_ticks = 0;
               got_result = 1'b1;
               if (b == rx_sum) res = '{kind: dle_rx_pkg::KIND_GOOD, value: dle_rx_pkg::CH_ACK};
               else res = '{kind: dle_rx_pkg::KIND_BAD, value: dle_rx_pkg::CH_NAK};
            end
         endcase
      end
   endfunction

   // driver: advance to the next queued item once the current transaction is taken
   always @(posedge clock) begin
      rx_item_type item;
      rsp_type     res;
      bit          got_result;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_step(req_tuser, req_tdata, got_result, res);
            if (got_result) predicted_results.push_back(res);
         end
         if (!req_tvalid || req_tready) begin
            if (rx_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 33)) begin
               item = rx_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item.cmd;
               req_tdata <= item.data;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transaction, and hold off once for a long stretch
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (predicted_results.size() == 0) begin
               $error("unexpected result: kind %0d value 0x%02h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind mismatch: expected %0d, got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== want.value) begin
                  $error("value mismatch: expected 0x%02h, got 0x%02h",
                         want.value, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (!hold_done && rsp_count >= 60) begin
            hold_left = 300;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_flow || $urandom_range(99) >= 33;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      rx_queue.push_back('{cmd: dle_rx_pkg::CMD_BYTE, data: b});
      queued_items++;
   endtask

   task automatic push_tick();
      rx_queue.push_back('{cmd: dle_rx_pkg::CMD_TICK, data: 8'($urandom_range(255))});
      queued_items++;
   endtask

   task automatic open_frame();
      push_byte(dle_rx_pkg::CH_STX);
      frame_sum = dle_rx_pkg::CH_STX;
   endtask

   // escape a literal DLE so it survives as payload
   task automatic put_payload(input logic [7:0] b);
      if (b == dle_rx_pkg::CH_DLE) push_byte(dle_rx_pkg::CH_DLE);
      push_byte(b);
      frame_sum = frame_sum + b;
   endtask

   // unknown byte after DLE is dropped; the following DLE then reads as a literal
   task automatic put_junk_escape();
      logic [7:0] x;
      x = 8'($urandom_range(255));
      if (x == dle_rx_pkg::CH_DLE || x == dle_rx_pkg::CH_ETX) x = 8'h00;
      push_byte(dle_rx_pkg::CH_DLE);
      push_byte(x);
      push_byte(dle_rx_pkg::CH_DLE);
      frame_sum = frame_sum + dle_rx_pkg::CH_DLE;
   endtask

   task automatic close_frame(input bit good);
      push_byte(dle_rx_pkg::CH_DLE);
      push_byte(dle_rx_pkg::CH_ETX);
      frame_sum = frame_sum + dle_rx_pkg::CH_ETX;
      push_byte(good ? frame_sum : frame_sum ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic drain();
      while (rx_queue.size() != 0 || req_tvalid || predicted_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // finish any open frame, then load the timeout while nothing is in flight
   task automatic write_timeout(input logic [15:0] ticks);
      drain();
      if (rx_phase != dle_rx_pkg::PH_IDLE) begin
         case (rx_phase)
            dle_rx_pkg::PH_DATA: begin
               push_byte(dle_rx_pkg::CH_DLE);
               push_byte(dle_rx_pkg::CH_ETX);
               push_byte(8'h00);
            end
            dle_rx_pkg::PH_ESC: begin
               push_byte(dle_rx_pkg::CH_ETX);
               push_byte(8'h00);
            end
            default: push_byte(8'h00);
         endcase
         drain();
      end
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= ticks;
      timeout_ticks = ticks;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int target;
      int sel;
      int n;
      logic [7:0] b;
      target = queued_items + count;
      while (queued_items < target) begin
         sel = $urandom_range(99);
         if (sel < 65) begin
            open_frame();
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(9) == 0) push_tick();
               if ($urandom_range(11) == 0) begin
                  put_junk_escape();
               end else begin
                  b = ($urandom_range(5) == 0) ? dle_rx_pkg::CH_DLE : 8'($urandom_range(255));
                  put_payload(b);
               end
            end
            close_frame($urandom_range(3) != 0);
         end else if (sel < 75) begin
            case ($urandom_range(2))
               0: push_byte(dle_rx_pkg::CH_ACK);
               1: push_byte(dle_rx_pkg::CH_NAK);
               default: push_byte(8'($urandom_range(255)));
            endcase
         end else if (sel < 85) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(1) == 0) push_tick();
               else push_byte(8'($urandom_range(255)));
            end
         end else begin
            // broken frame: ticks (which abort it when the timeout is short), stray escape, or leave it open
            open_frame();
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) put_payload(8'($urandom_range(255)));
            case ($urandom_range(2))
               0: begin
                  n = (timeout_ticks <= 20) ? int'(timeout_ticks) + 1 : $urandom_range(1, 8);
                  for (int i = 0; i < n; i++) push_tick();
               end
               1: begin
                  push_byte(dle_rx_pkg::CH_DLE);
                  push_byte(8'($urandom_range(255)));
               end
               default: ;
            endcase
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // peer responses, ignored byte and tick while idle
      push_byte(dle_rx_pkg::CH_ACK);
      push_byte(dle_rx_pkg::CH_NAK);
      push_byte(8'h00);
      push_tick();
      // good frame with extreme bytes, control bytes as payload, both escapes
      open_frame();
      put_payload(8'h00);
      put_payload(8'hFF);
      put_payload(dle_rx_pkg::CH_ACK);
      put_payload(dle_rx_pkg::CH_NAK);
      put_payload(dle_rx_pkg::CH_STX);
      put_payload(dle_rx_pkg::CH_DLE);
      put_junk_escape();
      close_frame(1'b1);
      // bad checksum
      open_frame();
      put_payload(8'h12);
      close_frame(1'b0);

      // zero timeout: first tick inside a frame aborts
      write_timeout(16'd0);
      open_frame();
      put_payload(8'h5A);
      push_tick();
      random_traffic(120);

      write_timeout(16'd1);
      random_traffic(150);

      write_timeout(16'hFFFF);
      steady_flow = 1'b1;
      random_traffic(150);
      drain();
      steady_flow = 1'b0;

      write_timeout(16'($urandom_range(2, 12)));
      random_traffic(250);

      write_timeout(dle_rx_pkg::TIMEOUT_RESET);
      random_traffic(200);

      write_timeout(16'($urandom_range(1, 65535)));
      random_traffic(100);

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && predicted_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
